// File: rtl/core/jsu_pkg.sv
// Shared types, codes and helpers of the JSON string unescape unit.
// Used by the decoder, the result buffer and the top level; no dependencies.
package jsu_pkg;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NONE          = 3'd0;
	localparam logic [2:0] ERR_NO_OPEN       = 3'd1;
	localparam logic [2:0] ERR_BAD_ESCAPE    = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX       = 3'd3;
	localparam logic [2:0] ERR_UNPAIRED_HIGH = 3'd4;
	localparam logic [2:0] ERR_BAD_LOW       = 3'd5;
	localparam logic [2:0] ERR_UNPAIRED_LOW  = 3'd6;
	localparam logic [2:0] ERR_EARLY_END     = 3'd7;

	localparam int unsigned MAX_RESULTS = 4;

	// all results caused by one input byte; bytes[0] goes out first
	typedef struct packed {
		logic [2:0]                   cnt;
		logic [MAX_RESULTS-1:0][7:0]  bytes;
		logic [1:0]                   kind;
		logic [2:0]                   err;
	} grp_t;

	// hex digit: {valid, value}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		case (c) inside
			[8'h30:8'h39]: r = {1'b1, c[3:0]};
			[8'h41:8'h46],
			[8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
			default:       r = 5'd0;
		endcase
		return r;
	endfunction

	// encode one code point as one to four UTF-8 bytes
	function automatic grp_t utf8_group(input logic [20:0] cp);
		grp_t g;
		g      = '0;
		g.kind = KIND_DATA;
		g.err  = ERR_NONE;
		if (cp < 21'h80) begin
			g.cnt      = 3'd1;
			g.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			g.cnt      = 3'd2;
			g.bytes[0] = {3'b110, cp[10:6]};
			g.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			g.cnt      = 3'd3;
			g.bytes[0] = {4'b1110, cp[15:12]};
			g.bytes[1] = {2'b10, cp[11:6]};
			g.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			g.cnt      = 3'd4;
			g.bytes[0] = {5'b11110, cp[20:18]};
			g.bytes[1] = {2'b10, cp[17:12]};
			g.bytes[2] = {2'b10, cp[11:6]};
			g.bytes[3] = {2'b10, cp[5:0]};
		end
		return g;
	endfunction

endpackage

// File: rtl/core/jsu_in_if.sv
// Input channel of the JSON string unescape unit: one raw text byte per beat.
// No dependencies.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_ended;

	modport source (output valid, output in_byte, output text_ended, input ready);
	modport sink   (input valid, input in_byte, input text_ended, output ready);
endinterface

// File: rtl/core/jsu_out_if.sv
// Output channel of the JSON string unescape unit: one decoded result per beat.
// No dependencies.
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic [2:0] error_code;
	logic       last;

	modport source (output valid, output out_byte, output kind, output error_code,
		output last, input ready);
	modport sink   (input valid, input out_byte, input kind, input error_code,
		input last, output ready);
endinterface

// File: rtl/core/json_string_unescape_unit.sv
// Top level of the JSON string unescape unit: input register, escape decoder
// and result buffer. Depends on jsu_pkg, jsu_in_if, jsu_out_if and the submodules.
//
// Usage:
//   rx carries raw bytes of a JSON string token, opening quote first; a beat
//   with text_ended set marks the end of the text and its byte is ignored.
//   tx carries results: decoded data bytes (kind 0), a close marker on the
//   closing quote (kind 1) or a numbered error (kind 2). last marks the final
//   result caused by one input byte. After an error the unit waits for a new
//   opening quote.
//   A byte taken on rx passes the input register and the result register to tx.
//   Throughput: one byte per cycle while each byte gives at most one result and
//   tx is ready; a byte that gives several results (a \u escape ends in up to
//   four UTF-8 bytes) holds the output while the single result buffer sends
//   them one beat per cycle. Bytes that give no result pass without waiting.
//   When tx stalls, the held result stays put; bytes giving no result still pass,
//   the next byte with results waits in the input register and rx.ready drops.
//   Reset (arst_n low) empties both registers and returns the parser to
//   waiting for an opening quote.
module json_string_unescape_unit (
	input  logic   clk,
	input  logic   arst_n,
	jsu_in_if.sink     rx,
	jsu_out_if.source  tx
);
	import jsu_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       ended_s1;
	grp_t       grp;
	logic       can_load;
	logic       advance;
	logic       load;

	// the registered byte moves on once its results fit in the buffer
	assign advance  = valid_s1 && ((grp.cnt == 3'd0) || can_load);
	assign load     = valid_s1 && (grp.cnt != 3'd0) && can_load;
	assign rx.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.in_byte;
			ended_s1 <= rx.text_ended;
		end
	end

	jsu_decoder u_decoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.c       (byte_s1),
		.ended   (ended_s1),
		.advance (advance),
		.grp     (grp)
	);

	jsu_result_buf u_result_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.grp      (grp),
		.can_load (can_load),
		.tx       (tx)
	);

endmodule

// File: rtl/core/jsu_decoder.sv
// Escape decoder: holds the string parse state and turns one registered byte
// into a group of up to four results. Depends on jsu_pkg.
module jsu_decoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     c,
	input  logic           ended,
	input  logic           advance,
	output jsu_pkg::grp_t  grp
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_BODY    = 3'd1,
		PH_ESC     = 3'd2,
		PH_HEX     = 3'd3,
		PH_WANT_BS = 3'd4,
		PH_WANT_U  = 3'd5,
		PH_LOW     = 3'd6
	} phase_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	phase_t      phase_q, phase_d;
	logic [1:0]  digit_q, digit_d;
	logic [15:0] high_q, high_d;
	logic [15:0] unit_q, unit_d;
	logic [4:0]  hex;
	logic [15:0] new_unit;
	logic [20:0] pair_cp;
	logic        fail;
	logic [2:0]  fail_code;

	assign hex      = hex_nibble(c);
	assign new_unit = {unit_q[11:0], hex[3:0]};
	assign pair_cp  = 21'h10000 + {1'b0, high_q[9:0], new_unit[9:0]};

	// next state and result group for the current byte
	always_comb begin
		phase_d   = phase_q;
		digit_d   = digit_q;
		high_d    = high_q;
		unit_d    = unit_q;
		fail      = 1'b0;
		fail_code = ERR_NONE;
		grp       = '0;
		grp.kind  = KIND_DATA;
		grp.err   = ERR_NONE;
		if (ended) begin
			if (phase_q != PH_IDLE) begin
				fail      = 1'b1;
				fail_code = ERR_EARLY_END;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (c != CH_QUOTE) begin
						fail      = 1'b1;
						fail_code = ERR_NO_OPEN;
					end else begin
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					if (c == CH_QUOTE) begin
						phase_d  = PH_IDLE;
						grp.cnt  = 3'd1;
						grp.kind = KIND_CLOSE;
					end else if (c == CH_BSL) begin
						phase_d = PH_ESC;
					end else begin
						grp.cnt      = 3'd1;
						grp.bytes[0] = c;
					end
				end
				PH_ESC: begin
					phase_d = PH_BODY;
					grp.cnt = 3'd1;
					case (c)
						CH_QUOTE: grp.bytes[0] = CH_QUOTE;
						CH_BSL:   grp.bytes[0] = CH_BSL;
						CH_SLASH: grp.bytes[0] = CH_SLASH;
						CH_B:     grp.bytes[0] = 8'h08;
						CH_F:     grp.bytes[0] = 8'h0C;
						CH_N:     grp.bytes[0] = 8'h0A;
						CH_R:     grp.bytes[0] = 8'h0D;
						CH_T:     grp.bytes[0] = 8'h09;
						CH_U: begin
							grp.cnt = 3'd0;
							phase_d = PH_HEX;
							digit_d = 2'd0;
							unit_d  = 16'd0;
						end
						default: begin
							fail      = 1'b1;
							fail_code = ERR_BAD_ESCAPE;
						end
					endcase
				end
				PH_HEX, PH_LOW: begin
					if (!hex[4]) begin
						fail      = 1'b1;
						fail_code = ERR_BAD_HEX;
					end else begin
						unit_d = new_unit;
						if (digit_q != 2'd3) begin
							digit_d = digit_q + 2'd1;
						end else begin
							digit_d = 2'd0;
							if (phase_q == PH_HEX) begin
								if (new_unit inside {[16'hD800:16'hDBFF]}) begin
									high_d  = new_unit;
									phase_d = PH_WANT_BS;
								end else if (new_unit inside {[16'hDC00:16'hDFFF]}) begin
									fail      = 1'b1;
									fail_code = ERR_UNPAIRED_LOW;
								end else begin
									phase_d = PH_BODY;
									grp     = utf8_group({5'd0, new_unit});
								end
							end else begin
								if (!(new_unit inside {[16'hDC00:16'hDFFF]})) begin
									fail      = 1'b1;
									fail_code = ERR_BAD_LOW;
								end else begin
									phase_d = PH_BODY;
									grp     = utf8_group(pair_cp);
								end
							end
						end
					end
				end
				PH_WANT_BS: begin
					if (c != CH_BSL) begin
						fail      = 1'b1;
						fail_code = ERR_UNPAIRED_HIGH;
					end else begin
						phase_d = PH_WANT_U;
					end
				end
				PH_WANT_U: begin
					if (c != CH_U) begin
						fail      = 1'b1;
						fail_code = ERR_UNPAIRED_HIGH;
					end else begin
						phase_d = PH_LOW;
						digit_d = 2'd0;
						unit_d  = 16'd0;
					end
				end
				default: begin
					fail      = 1'b1;
					fail_code = ERR_EARLY_END;
				end
			endcase
		end
		// any error: single error result, drop back to waiting
		if (fail) begin
			phase_d  = PH_IDLE;
			digit_d  = 2'd0;
			high_d   = 16'd0;
			unit_d   = 16'd0;
			grp      = '0;
			grp.cnt  = 3'd1;
			grp.kind = KIND_ERROR;
			grp.err  = fail_code;
		end
	end

	// advance parse state when the byte's results are handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			digit_q <= 2'd0;
			high_q  <= 16'd0;
			unit_q  <= 16'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
			high_q  <= high_d;
			unit_q  <= unit_d;
		end
	end

endmodule

// File: rtl/core/jsu_result_buf.sv
// Result register: holds one group of up to four results and sends them one
// beat at a time, taking the next group as the last beat leaves. Depends on jsu_pkg.
module jsu_result_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  jsu_pkg::grp_t  grp,
	output logic           can_load,
	jsu_out_if.source      tx
);
	import jsu_pkg::*;

	logic       valid_q;
	logic [1:0] idx_q;
	grp_t       grp_q;
	logic       at_end;
	logic       fire;

	assign at_end   = ({1'b0, idx_q} == (grp_q.cnt - 3'd1));
	assign fire     = valid_q && tx.ready;
	assign can_load = !valid_q || (tx.ready && at_end);

	// drive the current beat
	assign tx.valid      = valid_q;
	assign tx.out_byte   = grp_q.bytes[idx_q];
	assign tx.kind       = grp_q.kind;
	assign tx.error_code = grp_q.err;
	assign tx.last       = at_end;

	// track position within the held group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (fire) begin
			if (at_end) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// hold group payload
	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp;
		end
	end

endmodule
